@@ hw/rtl/epws_pkg.sv @@
// Shared types and constants of the EEPROM page write sequencer.
`default_nettype none
package epws_pkg;

	// item kinds carried in tuser
	localparam logic [1:0] K_START = 2'd0;
	localparam logic [1:0] K_DATA  = 2'd1;
	localparam logic [1:0] K_POLL  = 2'd2;
	localparam logic [1:0] K_NOP   = 2'd3;

	// register indexes on the configuration port
	localparam logic REG_WAIT_TICKS  = 1'b0;
	localparam logic REG_RETRY_LIMIT = 1'b1;

	localparam logic [7:0] WAIT_TICKS_RST  = 8'd5;
	localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

	typedef enum logic [1:0] {
		M_IDLE = 2'd0,
		M_LOAD = 2'd1,
		M_SEND = 2'd2,
		M_WAIT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_DIV,
		E_REM,
		E_READ,
		E_STAT
	} eng_t;

	typedef struct packed {
		logic [7:0] wait_ticks;
		logic [3:0] retry_limit;
	} cfg_t;

	typedef struct packed {
		logic        has_byte;
		logic [7:0]  out_byte;
		logic [15:0] byte_address;
		logic        last;
		logic        busy_res;
		logic        error;
	} res_t;

endpackage
`default_nettype wire

@@ hw/rtl/epws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module epws_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/epws_pgoff.sv @@
// Offset of a 16-bit address within its page, by reciprocal multiplication with a registered quotient.
`default_nettype none
module epws_pgoff #(
	parameter int unsigned PAGE_BYTES = 8,
	parameter int unsigned OFF_W      = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [15:0]       addr,
	output logic      [OFF_W-1:0]  off
);

	localparam int unsigned SH = 24;
	localparam logic [40:0] RECIP = 41'((64'd1 << SH) / PAGE_BYTES);

	logic [40:0] prod;
	logic [15:0] quot_s1;
	logic [22:0] qp;
	logic [22:0] rem_raw;
	logic [7:0]  rem;
	logic [7:0]  rem_c;

	// quotient may come out one low; the remainder then needs one correction
	assign prod = {25'd0, addr} * RECIP;

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s1 <= prod[39:24];
		end
	end

	assign qp      = {7'd0, quot_s1} * 23'(PAGE_BYTES);
	assign rem_raw = {7'd0, addr} - qp;
	assign rem     = rem_raw[7:0];
	assign rem_c   = (rem >= 8'(PAGE_BYTES)) ? (rem - 8'(PAGE_BYTES)) : rem;
	assign off     = rem_c[OFF_W-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/epws_seq.sv @@
// Write sequencer: scalar state, buffer memory, read pipeline and output register.
`default_nettype none
module epws_seq #(
	parameter int unsigned BUF_BYTES  = 64,
	parameter int unsigned PAGE_BYTES = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_valid,
	output logic                 s_ready,
	input  wire logic [1:0]      kind,
	input  wire logic [15:0]     start_address,
	input  wire logic [15:0]     length,
	input  wire logic [7:0]      data_byte,
	input  wire logic [31:0]     tick,
	input  wire logic            bus_ok,
	input  wire epws_pkg::cfg_t  cfg,
	output logic                 m_valid,
	input  wire logic            m_ready,
	output epws_pkg::res_t       res
);
	import epws_pkg::*;

	localparam int unsigned LEN_W   = $clog2(BUF_BYTES + 1);
	localparam int unsigned IDX_W   = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
	localparam int unsigned CHUNK_W = $clog2(PAGE_BYTES + 1);
	localparam int unsigned OFF_W   = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
	localparam int unsigned SUM_W   = (LEN_W > CHUNK_W) ? LEN_W : CHUNK_W;

	eng_t eng_q, eng_d;
	mode_t mode_q;

	logic [15:0]        cur_addr_q;
	logic [LEN_W-1:0]   bytes_left_q;
	logic [LEN_W-1:0]   load_ptr_q;
	logic [LEN_W-1:0]   rd_base_q;
	logic [LEN_W-1:0]   rd_start_q;
	logic [31:0]        wait_start_q;
	logic [3:0]         retries_q;
	logic               error_q;
	logic [31:0]        tick_q;
	logic               bus_ok_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [CHUNK_W-1:0] rd_cnt_q;
	logic [15:0]        send_addr_q;

	logic               rd_vld_s1;
	logic [15:0]        addr_s1;
	logic               last_s1;
	logic               busy_s1;
	logic               err_s1;
	logic [7:0]         rdata;

	logic               m_valid_q;
	res_t               out_q;

	logic               s_accept;
	logic               send_ok;
	logic               data_ok;
	logic               wait_done;
	logic [31:0]        elapsed;
	logic [LEN_W-1:0]   len_c;
	logic [LEN_W-1:0]   lp_inc;
	logic [OFF_W-1:0]   pg_off;
	logic [CHUNK_W-1:0] room;
	logic [CHUNK_W-1:0] chunk;
	logic [SUM_W-1:0]   rd_sum;
	logic               cnt_last;
	logic               out_free;
	logic               out_take_s1;
	logic               mem_we;
	logic               rd_issue;
	logic               stat_load;

	assign s_accept  = s_valid && s_ready;
	assign send_ok   = (mode_q == M_SEND) && (bytes_left_q != '0);
	assign data_ok   = (mode_q == M_LOAD) && (load_ptr_q < bytes_left_q);
	assign lp_inc    = load_ptr_q + LEN_W'(1);
	assign elapsed   = tick - wait_start_q;
	assign wait_done = elapsed >= {24'd0, cfg.wait_ticks};
	assign len_c     = (length > 16'(BUF_BYTES)) ? LEN_W'(BUF_BYTES) : LEN_W'(length);

	assign room  = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(pg_off);
	assign chunk = (SUM_W'(bytes_left_q) < SUM_W'(room)) ? CHUNK_W'(bytes_left_q) : room;

	assign rd_sum   = SUM_W'(rd_start_q) + SUM_W'(rd_cnt_q);
	assign cnt_last = (rd_cnt_q + CHUNK_W'(1)) == chunk_q;

	assign out_free    = !m_valid_q || m_ready;
	assign out_take_s1 = rd_vld_s1 && out_free;

	epws_pgoff #(
		.PAGE_BYTES (PAGE_BYTES)
	) u_pgoff (
		.clk  (clk),
		.en   (eng_q == E_DIV),
		.addr (cur_addr_q),
		.off  (pg_off)
	);

	epws_ram #(
		.WIDTH (8),
		.DEPTH (BUF_BYTES)
	) u_buf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (load_ptr_q[IDX_W-1:0]),
		.wdata (data_byte),
		.re    (rd_issue),
		.raddr (rd_sum[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		eng_d = eng_q;
		unique case (eng_q)
			E_IDLE: begin
				if (s_valid) begin
					eng_d = (kind == K_POLL && send_ok) ? E_DIV : E_STAT;
				end
			end
			E_DIV:  eng_d = E_REM;
			E_REM:  eng_d = E_READ;
			E_READ: begin
				if (rd_issue && cnt_last) begin
					eng_d = E_IDLE;
				end
			end
			E_STAT: begin
				if (stat_load) begin
					eng_d = E_IDLE;
				end
			end
			default: eng_d = E_IDLE;
		endcase
	end

	always_comb begin
		s_ready   = 1'b0;
		mem_we    = 1'b0;
		rd_issue  = 1'b0;
		stat_load = 1'b0;
		unique case (eng_q)
			E_IDLE: begin
				s_ready = 1'b1;
				mem_we  = s_valid && (kind == K_DATA) && data_ok;
			end
			E_READ: rd_issue  = !rd_vld_s1 || out_take_s1;
			E_STAT: stat_load = !rd_vld_s1 && out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q <= E_IDLE;
		end else begin
			eng_q <= eng_d;
		end
	end

	// scalar write state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			cur_addr_q   <= '0;
			bytes_left_q <= '0;
			load_ptr_q   <= '0;
			rd_base_q    <= '0;
			wait_start_q <= '0;
			retries_q    <= '0;
			error_q      <= 1'b0;
		end else if (eng_q == E_IDLE && s_accept) begin
			unique case (kind)
				K_START: begin
					cur_addr_q   <= start_address;
					bytes_left_q <= len_c;
					load_ptr_q   <= '0;
					rd_base_q    <= '0;
					wait_start_q <= '0;
					retries_q    <= '0;
					error_q      <= 1'b0;
					mode_q       <= (len_c == '0) ? M_IDLE : M_LOAD;
				end
				K_DATA: begin
					if (data_ok) begin
						load_ptr_q <= lp_inc;
						if (lp_inc >= bytes_left_q) begin
							mode_q <= M_SEND;
						end
					end
				end
				K_POLL: begin
					if (mode_q == M_WAIT) begin
						if (wait_done) begin
							mode_q <= (bytes_left_q != '0) ? M_SEND : M_IDLE;
						end
					end else if (mode_q == M_SEND && !send_ok) begin
						mode_q <= M_IDLE;
					end
				end
				K_NOP: begin
				end
				default: begin
				end
			endcase
		end else if (eng_q == E_REM) begin
			if (bus_ok_q) begin
				cur_addr_q   <= cur_addr_q + 16'(chunk);
				bytes_left_q <= bytes_left_q - LEN_W'(chunk);
				rd_base_q    <= rd_base_q + LEN_W'(chunk);
				retries_q    <= '0;
				wait_start_q <= tick_q;
				mode_q       <= M_WAIT;
			end else if (retries_q < cfg.retry_limit) begin
				retries_q <= retries_q + 4'd1;
			end else begin
				error_q      <= 1'b1;
				mode_q       <= M_IDLE;
				bytes_left_q <= '0;
			end
		end
	end

	// poll operands and chunk bookkeeping
	always_ff @(posedge clk) begin
		if (s_accept) begin
			tick_q   <= tick;
			bus_ok_q <= bus_ok;
		end
		if (eng_q == E_REM) begin
			chunk_q     <= chunk;
			send_addr_q <= cur_addr_q;
			rd_start_q  <= rd_base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
		end else if (eng_q == E_REM) begin
			rd_cnt_q <= '0;
		end else if (rd_issue) begin
			rd_cnt_q <= rd_cnt_q + CHUNK_W'(1);
		end
	end

	// read stage: memory data with its word attributes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else if (rd_issue) begin
			rd_vld_s1 <= 1'b1;
		end else if (out_take_s1) begin
			rd_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			addr_s1 <= send_addr_q + 16'(rd_cnt_q);
			last_s1 <= cnt_last;
			busy_s1 <= mode_q != M_IDLE;
			err_s1  <= error_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_take_s1 || stat_load) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take_s1) begin
			out_q.has_byte     <= 1'b1;
			out_q.out_byte     <= rdata;
			out_q.byte_address <= addr_s1;
			out_q.last         <= last_s1;
			out_q.busy_res     <= busy_s1;
			out_q.error        <= err_s1;
		end else if (stat_load) begin
			out_q.has_byte     <= 1'b0;
			out_q.out_byte     <= '0;
			out_q.byte_address <= '0;
			out_q.last         <= 1'b1;
			out_q.busy_res     <= mode_q != M_IDLE;
			out_q.error        <= error_q;
		end
	end

	assign m_valid = m_valid_q;
	assign res     = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/eeprom_page_write_sequencer_core.sv @@
// Top level of the EEPROM page write sequencer: stream ports, register port, sequencer.
//
//  channel   | direction | contents
//  s_*       | in        | start, buffer byte or poll word
//  m_*       | out       | byte to write with its address, or a status word
//  APB       | in/out    | wait_ticks at 0x0, retry_limit at 0x4
//
// Start, data, no-op and non-sending poll words each give one status word.
// A sending poll is taken in E_IDLE, passes E_DIV and E_REM for the page offset and
// chunk size, then issues one buffer read per byte through the single read port.
// Reset clears the engine, mode, write state and valid flags; poll operands, chunk bookkeeping
// and buffer contents are undefined until loaded. A stalled m_tready holds the output register
// and the read stage; one more word is taken, then input waits.
`default_nettype none
module eeprom_page_write_sequencer_core #(
	parameter int unsigned BUF_BYTES  = 64,
	parameter int unsigned PAGE_BYTES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // start_address, length, data_byte, tick, bus_ok, zero pad
	input  wire logic [1:0]  s_tuser,  // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // out_byte, byte_address, busy_res, error, zero pad
	output logic             m_tuser,  // has_byte
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import epws_pkg::*;

	cfg_t cfg_q;
	res_t res;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_ticks  <= WAIT_TICKS_RST;
			cfg_q.retry_limit <= RETRY_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WAIT_TICKS:  cfg_q.wait_ticks  <= pwdata[7:0];
				REG_RETRY_LIMIT: cfg_q.retry_limit <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WAIT_TICKS:  prdata = {24'd0, cfg_q.wait_ticks};
			REG_RETRY_LIMIT: prdata = {28'd0, cfg_q.retry_limit};
			default:         prdata = '0;
		endcase
	end

	epws_seq #(
		.BUF_BYTES  (BUF_BYTES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_valid       (s_tvalid),
		.s_ready       (s_tready),
		.kind          (s_tuser),
		.start_address (s_tdata[15:0]),
		.length        (s_tdata[31:16]),
		.data_byte     (s_tdata[39:32]),
		.tick          (s_tdata[71:40]),
		.bus_ok        (s_tdata[72]),
		.cfg           (cfg_q),
		.m_valid       (m_tvalid),
		.m_ready       (m_tready),
		.res           (res)
	);

	assign m_tdata = {6'd0, res.error, res.busy_res, res.byte_address, res.out_byte};
	assign m_tuser = res.has_byte;
	assign m_tlast = res.last;

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tlast)
		else $error("status word without last");

	a_byte_active: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[24] || m_tdata[25]))
		else $error("byte word while neither busy nor in error");

	a_error_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[25]) |-> !m_tdata[24])
		else $error("error flagged while still busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast)))
		else $error("output word changed while stalled");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the EEPROM page write sequencer core.
`timescale 1ns / 100ps
module tb_top;
	import epws_pkg::*;

	localparam int unsigned BUF_BYTES      = 64;
	localparam int unsigned PAGE_BYTES     = 8;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned END_CYCLES     = 20;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [15:0] len;
		logic [7:0]  byte_v;
		logic [31:0] tick;
		logic        ok;
	} word_t;

	typedef struct packed {
		word_t w;
		bit    typed;
		logic  busy;
		logic  err;
	} drow_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predicted sequencer state
	logic [7:0]  img_buf [BUF_BYTES];
	logic [15:0] base_adr;
	logic [15:0] cur_adr;
	logic [6:0]  left_cnt;
	logic [6:0]  fill_ptr;
	mode_t       seq_mode;
	logic [31:0] wait_from;
	logic [3:0]  retry_cnt;
	logic        err_flag;
	cfg_t        cfg_now;

	res_t        due_words [$];
	int          effective_items;
	int          fail_cnt;
	logic [31:0] now_tick;
	bit          hold_req;
	bit          no_gaps;

	drow_t dir_rows [25] = '{
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'h0000_0000, 1'b0}, 1'b1, 1'b0, 1'b0},
		'{'{K_NOP,   16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1}, 1'b1, 1'b0, 1'b0},
		'{'{K_DATA,  16'h0000, 16'h0000, 8'hFF, 32'h0000_0000, 1'b0}, 1'b1, 1'b0, 1'b0},
		'{'{K_START, 16'hFFFE, 16'h0000, 8'h00, 32'h0000_0000, 1'b0}, 1'b1, 1'b0, 1'b0},
		'{'{K_START, 16'hFFFE, 16'h0003, 8'h00, 32'h0000_0000, 1'b0}, 1'b1, 1'b1, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'h0000_0000, 1'b1}, 1'b1, 1'b1, 1'b0},
		'{'{K_DATA,  16'h0000, 16'h0000, 8'h00, 32'h0000_0000, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_DATA,  16'h0000, 16'h0000, 8'hFF, 32'h0000_0000, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_DATA,  16'h0000, 16'h0000, 8'hA5, 32'h0000_0000, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_DATA,  16'h0000, 16'h0000, 8'h3C, 32'h0000_0000, 1'b0}, 1'b1, 1'b1, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'h0000_0064, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'hFFFF_FFFE, 1'b1}, 1'b0, 1'b0, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'h0000_0002, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'h0000_0003, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'h0000_000A, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'h0000_000B, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'h0000_000C, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'h0000_000D, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'h0000_0014, 1'b1}, 1'b1, 1'b0, 1'b1},
		'{'{K_START, 16'h1234, 16'hFFFF, 8'h00, 32'h0000_0000, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_START, 16'h0005, 16'h0001, 8'h00, 32'h0000_0000, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_DATA,  16'h0000, 16'h0000, 8'h5A, 32'h0000_0000, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'hFFFF_FFFF, 1'b1}, 1'b0, 1'b0, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'hFFFF_FFFF, 1'b0}, 1'b0, 1'b0, 1'b0},
		'{'{K_POLL,  16'h0000, 16'h0000, 8'h00, 32'h0000_0004, 1'b1}, 1'b0, 1'b0, 1'b0}
	};

	eeprom_page_write_sequencer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic word_t mk(input logic [1:0] kind, input logic [15:0] addr,
			input logic [15:0] len, input logic [7:0] byte_v, input logic [31:0] tick,
			input logic ok);
		word_t w;
		w.kind   = kind;
		w.addr   = addr;
		w.len    = len;
		w.byte_v = byte_v;
		w.tick   = tick;
		w.ok     = ok;
		return w;
	endfunction

	function automatic word_t noise_word(input int unsigned lo);
		return mk(2'($urandom_range(lo, 3)), 16'($urandom), 16'($urandom), 8'($urandom),
			$urandom, 1'($urandom));
	endfunction

	// Work out the words one input word yields and advance the predicted state.
	task automatic predict_page_words(input word_t w, input bit keep);
		res_t          r;
		logic [15:0]   first;
		logic [31:0]   dt;
		int unsigned   room;
		int unsigned   chunk;
		int unsigned   idx;
		int unsigned   n;
		bit            acted;
		acted = 1'b1;
		case (w.kind)
			K_START: begin
				n = (w.len > BUF_BYTES) ? BUF_BYTES : w.len;
				base_adr  = w.addr;
				cur_adr   = w.addr;
				left_cnt  = 7'(n);
				fill_ptr  = '0;
				wait_from = '0;
				retry_cnt = '0;
				err_flag  = 1'b0;
				if (n == 0) seq_mode = M_IDLE;
				else seq_mode = M_LOAD;
			end
			K_DATA: begin
				if (seq_mode == M_LOAD && fill_ptr < left_cnt) begin
					img_buf[fill_ptr] = w.byte_v;
					fill_ptr++;
					if (fill_ptr >= left_cnt) seq_mode = M_SEND;
				end else begin
					acted = 1'b0;
				end
			end
			K_POLL: begin
				if (seq_mode == M_SEND && left_cnt != 0) begin
					room  = PAGE_BYTES - (cur_adr % PAGE_BYTES);
					chunk = (left_cnt > room) ? room : left_cnt;
					idx   = 16'(cur_adr - base_adr);
					first = cur_adr;
					if (w.ok) begin
						cur_adr   = cur_adr + 16'(chunk);
						left_cnt  = left_cnt - 7'(chunk);
						retry_cnt = '0;
						wait_from = w.tick;
						seq_mode  = M_WAIT;
					end else if (retry_cnt < cfg_now.retry_limit) begin
						retry_cnt++;
					end else begin
						err_flag = 1'b1;
						seq_mode = M_IDLE;
						left_cnt = '0;
					end
					for (int i = 0; i < chunk; i++) begin
						r.has_byte     = 1'b1;
						r.out_byte     = img_buf[idx + i];
						r.byte_address = first + 16'(i);
						r.last         = (i + 1 == chunk);
						r.busy_res     = (seq_mode != M_IDLE);
						r.error        = err_flag;
						if (keep) due_words.push_back(r);
					end
					effective_items++;
					return;
				end
				if (seq_mode == M_WAIT) begin
					dt = w.tick - wait_from;
					if (dt >= {24'b0, cfg_now.wait_ticks}) begin
						if (left_cnt != 0) seq_mode = M_SEND;
						else seq_mode = M_IDLE;
					end
				end else if (seq_mode == M_SEND) begin
					seq_mode = M_IDLE;
				end
			end
			default: begin
				acted = 1'b0;
			end
		endcase
		r          = '0;
		r.last     = 1'b1;
		r.busy_res = (seq_mode != M_IDLE);
		r.error    = err_flag;
		if (keep) due_words.push_back(r);
		if (acted) effective_items++;
	endtask

	task automatic send_word(input word_t w, input bit typed, input res_t typed_res);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  <= w.kind;
		s_tdata  <= {7'b0, w.ok, w.tick, w.byte_v, w.len, w.addr};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_page_words(w, !typed);
		if (typed) due_words.push_back(typed_res);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (idx == REG_RETRY_LIMIT) cfg_now.retry_limit = val[3:0];
		else cfg_now.wait_ticks = val[7:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		while (due_words.size() != 0) @(negedge clk);
	endtask

	// One buffered write: start, load, then poll until the block goes idle or 80 polls are sent.
	task automatic run_write_seq();
		int unsigned len;
		int unsigned n;
		int unsigned pick;
		int unsigned polls;
		pick = $urandom_range(0, 11);
		if (pick == 0) len = $urandom_range(65, 65535);
		else if (pick == 1) len = BUF_BYTES;
		else len = $urandom_range(1, 12);
		if ($urandom_range(0, 7) == 0) send_word(noise_word(0), 1'b0, '0);
		send_word(mk(K_START, 16'($urandom), 16'(len), 8'($urandom), $urandom, 1'($urandom)),
			1'b0, '0);
		n = (len > BUF_BYTES) ? BUF_BYTES : len;
		for (int i = 0; i < n; i++) begin
			// drop the write half loaded now and then
			if ($urandom_range(0, 14) == 0) return;
			if ($urandom_range(0, 19) == 0) send_word(noise_word(2), 1'b0, '0);
			send_word(mk(K_DATA, 16'($urandom), 16'($urandom), 8'($urandom), $urandom,
				1'($urandom)), 1'b0, '0);
		end
		polls = 0;
		while (seq_mode != M_IDLE && polls < 80) begin
			if ($urandom_range(0, 15) == 0) now_tick = $urandom;
			else now_tick = now_tick + $urandom_range(0, 2 * cfg_now.wait_ticks + 2);
			send_word(mk(K_POLL, 16'($urandom), 16'($urandom), 8'($urandom), now_tick,
				1'($urandom_range(0, 3) != 0)), 1'b0, '0);
			polls++;
			if ($urandom_range(0, 24) == 0)
				send_word(mk(K_DATA, 16'($urandom), 16'($urandom), 8'($urandom), $urandom,
					1'($urandom)), 1'b0, '0);
		end
	endtask

	initial begin : result_side
		int   stall;
		res_t want;
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 6);
			if (hold_req) begin
				stall    = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			if (due_words.size() == 0) begin
				$error("word with nothing expected: tdata %h tuser %b tlast %b",
					m_tdata, m_tuser, m_tlast);
				fail_cnt++;
			end else begin
				want = due_words.pop_front();
				if (m_tuser !== want.has_byte) begin
					$error("has_byte: expected %0h, got %0h", want.has_byte, m_tuser);
					fail_cnt++;
				end
				if (m_tdata[7:0] !== want.out_byte) begin
					$error("out_byte: expected %0h, got %0h", want.out_byte, m_tdata[7:0]);
					fail_cnt++;
				end
				if (m_tdata[23:8] !== want.byte_address) begin
					$error("byte_address: expected %0h, got %0h", want.byte_address,
						m_tdata[23:8]);
					fail_cnt++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0h, got %0h", want.last, m_tlast);
					fail_cnt++;
				end
				if (m_tdata[24] !== want.busy_res) begin
					$error("busy_res: expected %0h, got %0h", want.busy_res, m_tdata[24]);
					fail_cnt++;
				end
				if (m_tdata[25] !== want.error) begin
					$error("error: expected %0h, got %0h", want.error, m_tdata[25]);
					fail_cnt++;
				end
			end
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		cfg_t plan;
		int   target;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= K_NOP;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		base_adr        = '0;
		cur_adr         = '0;
		left_cnt        = '0;
		fill_ptr        = '0;
		seq_mode        = M_IDLE;
		wait_from       = '0;
		retry_cnt       = '0;
		err_flag        = 1'b0;
		cfg_now         = {WAIT_TICKS_RST, RETRY_LIMIT_RST};
		effective_items = 0;
		fail_cnt        = 0;
		now_tick        = '0;
		hold_req        = 1'b0;
		no_gaps         = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].typed,
				{1'b0, 8'h00, 16'h0000, 1'b1, dir_rows[i].busy, dir_rows[i].err});
		drain_outputs();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: plan = {8'd0, 4'd0};
				1: plan = {8'd255, 4'd15};
				3: plan = {8'd1, 4'd1};
				default: plan = {8'($urandom), 4'($urandom)};
			endcase
			cfg_write(REG_WAIT_TICKS, {24'b0, plan.wait_ticks});
			cfg_write(REG_RETRY_LIMIT, {28'b0, plan.retry_limit});
			no_gaps  = (p == 2);
			hold_req = (p == 1);
			target   = 25 + 35 * (p + 1);
			while (effective_items < target) run_write_seq();
			drain_outputs();
		end
		no_gaps = 1'b0;
		repeat (END_CYCLES) @(negedge clk);

		if (fail_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
